FILE: src/btbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitwise trie bucket map package
// Shared sizes, codes, node layout and pool allocator interface types.
// ----------------------------------------------------------------------------
package btbm_pkg;

   localparam int BUCKET_SIZE = 8;
   localparam int NODE_POOL   = 256;
   localparam int BUCKET_POOL = 128;
   localparam int KEY_BITS    = 32;
   localparam int GROUP       = 16;

   localparam int NODE_IDX_W  = $clog2(NODE_POOL);
   localparam int BKT_IDX_W   = $clog2(BUCKET_POOL);
   localparam int SLOT_W      = $clog2(BUCKET_SIZE);
   localparam int FILL_W      = $clog2(BUCKET_SIZE + 1);
   localparam int KV_ADDR_W   = BKT_IDX_W + SLOT_W;
   localparam int KV_DEPTH    = BUCKET_POOL * BUCKET_SIZE;
   localparam int H_W         = $clog2(KEY_BITS + 1);
   localparam int KEY_IDX_W   = $clog2(KEY_BITS);
   localparam int NODE_CNT_W  = $clog2(NODE_POOL + 1);
   localparam int BKT_CNT_W   = $clog2(BUCKET_POOL + 1);
   localparam int NODE_GROUPS = NODE_POOL / GROUP;
   localparam int BKT_GROUPS  = BUCKET_POOL / GROUP;
   localparam int NG_W        = $clog2(NODE_GROUPS);
   localparam int BG_W        = $clog2(BKT_GROUPS);
   localparam int LO_W        = $clog2(GROUP);

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_GET    = 2'd1;
   localparam logic [1:0] FUNC_DELETE = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FAIL = 2'd2;

   typedef struct packed {
      logic [NODE_IDX_W-1:0] zero;
      logic [NODE_IDX_W-1:0] one;
      logic [BKT_IDX_W-1:0]  bucket;
      logic                  has_zero;
      logic                  has_one;
      logic                  has_bucket;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   typedef struct packed {
      logic                  find;
      logic                  node_take;
      logic                  node_rel;
      logic [NODE_IDX_W-1:0] node_idx;
      logic                  bkt_take;
      logic                  bkt_rel;
      logic [BKT_IDX_W-1:0]  bkt_idx;
   } alloc_cmd_type;

   typedef struct packed {
      logic [NODE_IDX_W-1:0] node_pick;
      logic [BKT_IDX_W-1:0]  bkt_pick;
      logic [NODE_CNT_W-1:0] node_cnt;
      logic [BKT_CNT_W-1:0]  bkt_cnt;
   } alloc_stat_type;

   function automatic logic [LO_W-1:0] lowest_set(input logic [GROUP-1:0] v);
      logic [LO_W-1:0] idx;
      idx = '0;
      for (int i = GROUP - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = LO_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

FILE: src/bitwise_trie_bucket_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitwise trie bucket map
// Key-to-value map in a binary trie of node memory with leaf buckets.
// ----------------------------------------------------------------------------
// A request carries req_func (insert, get or delete), req_key and req_value
// and is taken on the req_ channel when req_valid and req_ready are high.
// Exactly one response follows on the rsp_ channel with rsp_status and
// rsp_found_value; the value is zero unless the status is OK.
// The block handles one request at a time: req_ready is high only while it
// is idle, and a response waits in its register until rsp_ready takes it.
// The trie walk goes through the node memory, which has one write port and
// one read port with registered read data: each trie level a lookup visits
// is read and evaluated, an insert also descends at each level, and where
// the insert has to create the child node it searches the pool, takes the
// node and links it. A bucket scan then reads each stored pair in turn, and
// a delete shifts each later pair down one slot. A split of a full bucket
// counts, copies and relinks, with a lowest-free search per grant; the
// worst insert splits at every one of the 32 levels.
// Reset empties the map at once: the pool free maps are flip-flops and no
// memory clearing pass is needed.
// ----------------------------------------------------------------------------
module bitwise_trie_bucket_map (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_found_value
);

   typedef enum logic [5:0] {
      S_IDLE, S_ROOT, S_NODE_RD, S_NODE_EV, S_FIND1, S_FIND2,
      S_INS_FILL, S_INS_DESC, S_INS_NEWN, S_INS_LINK, S_INS_NEWB, S_INS_PUSH,
      S_SPL_CNT_RD, S_SPL_CNT, S_SPL_CHK, S_SPL_TAKE_O, S_SPL_TAKE_Z,
      S_SPL_CP_RD, S_SPL_CP_WR, S_SPL_FILL_O, S_SPL_FILL_Z,
      S_SPL_NODE_O, S_SPL_NODE_Z, S_SPL_RELINK,
      S_LK_FILL, S_LK_RD, S_LK_CMP, S_LK_FREE, S_LK_UNLINK,
      S_DEL_RD, S_DEL_WR, S_RESP
   } state_type;

   state_type                        state_ff;
   state_type                        ret_ff;
   logic [1:0]                       func_ff;
   logic [31:0]                      key_ff;
   logic [31:0]                      value_ff;
   logic                             root_ff;
   logic [btbm_pkg::NODE_IDX_W-1:0]  n_ff;
   logic [btbm_pkg::H_W-1:0]         h_ff;
   btbm_pkg::node_type               cur_ff;
   btbm_pkg::node_type               par_ff;
   logic [btbm_pkg::NODE_IDX_W-1:0]  par_idx_ff;
   logic                             has_par_ff;
   logic [btbm_pkg::BKT_IDX_W-1:0]   bkt_ff;
   logic [btbm_pkg::BKT_IDX_W-1:0]   bo_ff;
   logic [btbm_pkg::BKT_IDX_W-1:0]   bz_ff;
   logic [btbm_pkg::FILL_W-1:0]      fill_ff;
   logic [btbm_pkg::FILL_W-1:0]      i_ff;
   logic [btbm_pkg::FILL_W-1:0]      ones_ff;
   logic [btbm_pkg::FILL_W-1:0]      zeros_ff;
   logic [btbm_pkg::FILL_W-1:0]      fo_ff;
   logic [btbm_pkg::FILL_W-1:0]      fz_ff;
   logic [1:0]                       status_ff;
   logic [31:0]                      found_ff;

   logic                             node_we;
   logic [btbm_pkg::NODE_IDX_W-1:0]  node_waddr;
   btbm_pkg::node_type               node_wdata;
   logic [btbm_pkg::NODE_IDX_W-1:0]  node_raddr;
   btbm_pkg::node_type               node_rdata;
   logic                             fill_we;
   logic [btbm_pkg::BKT_IDX_W-1:0]   fill_waddr;
   logic [btbm_pkg::FILL_W-1:0]      fill_wdata;
   logic [btbm_pkg::BKT_IDX_W-1:0]   fill_raddr;
   logic [btbm_pkg::FILL_W-1:0]      fill_rdata;
   logic                             kv_we;
   logic [btbm_pkg::KV_ADDR_W-1:0]   kv_waddr;
   logic [31:0]                      key_wdata;
   logic [31:0]                      val_wdata;
   logic [btbm_pkg::KV_ADDR_W-1:0]   kv_raddr;
   logic [31:0]                      key_rdata;
   logic [31:0]                      val_rdata;
   btbm_pkg::alloc_cmd_type          acmd;
   btbm_pkg::alloc_stat_type         astat;

   logic                             key_bit;
   logic                             split_bit;
   logic                             at_depth;
   logic [btbm_pkg::FILL_W-1:0]      i_next;
   logic [1:0]                       need;
   btbm_pkg::node_type               leaf_node;
   btbm_pkg::node_type               par_upd;

   btbm_ram #(.WIDTH(btbm_pkg::NODE_W), .DEPTH(btbm_pkg::NODE_POOL)) u_node_ram (
      .clock(clock), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
      .raddr(node_raddr), .rdata(node_rdata)
   );

   btbm_ram #(.WIDTH(btbm_pkg::FILL_W), .DEPTH(btbm_pkg::BUCKET_POOL)) u_fill_ram (
      .clock(clock), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
      .raddr(fill_raddr), .rdata(fill_rdata)
   );

   btbm_ram #(.WIDTH(32), .DEPTH(btbm_pkg::KV_DEPTH)) u_key_ram (
      .clock(clock), .we(kv_we), .waddr(kv_waddr), .wdata(key_wdata),
      .raddr(kv_raddr), .rdata(key_rdata)
   );

   btbm_ram #(.WIDTH(32), .DEPTH(btbm_pkg::KV_DEPTH)) u_val_ram (
      .clock(clock), .we(kv_we), .waddr(kv_waddr), .wdata(val_wdata),
      .raddr(kv_raddr), .rdata(val_rdata)
   );

   btbm_alloc u_alloc (
      .clock(clock), .reset(reset), .cmd(acmd), .stat(astat)
   );

   assign key_bit   = key_ff[h_ff[btbm_pkg::KEY_IDX_W-1:0]];
   assign split_bit = key_rdata[h_ff[btbm_pkg::KEY_IDX_W-1:0]];
   assign at_depth  = (h_ff == btbm_pkg::H_W'(btbm_pkg::KEY_BITS));
   assign i_next    = i_ff + 1'b1;
   assign need      = {1'b0, (ones_ff != '0)} + {1'b0, (zeros_ff != '0)};

   always_comb begin
      leaf_node            = cur_ff;
      leaf_node.has_bucket = 1'b0;
      par_upd              = par_ff;
      if (par_ff.has_zero && (par_ff.zero == n_ff)) begin
         par_upd.has_zero = 1'b0;
      end else begin
         par_upd.has_one = 1'b0;
      end
   end

   always_comb begin
      node_we    = 1'b0;
      node_waddr = n_ff;
      node_wdata = cur_ff;
      node_raddr = n_ff;
      fill_we    = 1'b0;
      fill_waddr = bkt_ff;
      fill_wdata = '0;
      fill_raddr = node_rdata.bucket;
      kv_we      = 1'b0;
      kv_waddr   = {bkt_ff, i_ff[btbm_pkg::SLOT_W-1:0]};
      key_wdata  = key_ff;
      val_wdata  = value_ff;
      kv_raddr   = {bkt_ff, i_ff[btbm_pkg::SLOT_W-1:0]};
      acmd       = '0;
      acmd.node_idx = astat.node_pick;
      acmd.bkt_idx  = astat.bkt_pick;
      case (state_ff)
         S_ROOT: begin
            node_we       = 1'b1;
            node_waddr    = '0;
            node_wdata    = '0;
            acmd.node_take = 1'b1;
            acmd.node_idx  = '0;
         end
         S_FIND1: begin
            acmd.find = 1'b1;
         end
         S_INS_NEWN: begin
            node_we        = 1'b1;
            node_waddr     = astat.node_pick;
            node_wdata     = '0;
            acmd.node_take = 1'b1;
         end
         S_INS_LINK: begin
            node_we = 1'b1;
         end
         S_INS_NEWB: begin
            node_we               = 1'b1;
            node_wdata.bucket     = astat.bkt_pick;
            node_wdata.has_bucket = 1'b1;
            acmd.bkt_take         = 1'b1;
         end
         S_INS_PUSH: begin
            kv_we      = 1'b1;
            kv_waddr   = {bkt_ff, fill_ff[btbm_pkg::SLOT_W-1:0]};
            fill_we    = 1'b1;
            fill_wdata = fill_ff + 1'b1;
         end
         S_SPL_TAKE_O, S_SPL_TAKE_Z: begin
            acmd.bkt_take = 1'b1;
         end
         S_SPL_CP_WR: begin
            kv_we     = 1'b1;
            key_wdata = key_rdata;
            val_wdata = val_rdata;
            if (split_bit) begin
               kv_waddr = {bo_ff, fo_ff[btbm_pkg::SLOT_W-1:0]};
            end else begin
               kv_waddr = {bz_ff, fz_ff[btbm_pkg::SLOT_W-1:0]};
            end
         end
         S_SPL_FILL_O: begin
            fill_we    = (ones_ff != '0);
            fill_waddr = bo_ff;
            fill_wdata = fo_ff;
         end
         S_SPL_FILL_Z: begin
            fill_we    = (zeros_ff != '0);
            fill_waddr = bz_ff;
            fill_wdata = fz_ff;
         end
         S_SPL_NODE_O, S_SPL_NODE_Z: begin
            node_we               = 1'b1;
            node_waddr            = astat.node_pick;
            node_wdata            = '0;
            node_wdata.bucket     = (state_ff == S_SPL_NODE_O) ? bo_ff : bz_ff;
            node_wdata.has_bucket = 1'b1;
            acmd.node_take        = 1'b1;
         end
         S_SPL_RELINK: begin
            node_we      = 1'b1;
            node_wdata   = leaf_node;
            acmd.bkt_rel = 1'b1;
            acmd.bkt_idx = bkt_ff;
         end
         S_LK_FREE: begin
            node_we      = 1'b1;
            node_wdata   = leaf_node;
            acmd.bkt_rel = 1'b1;
            acmd.bkt_idx = bkt_ff;
         end
         S_LK_UNLINK: begin
            node_we       = 1'b1;
            node_waddr    = par_idx_ff;
            node_wdata    = par_upd;
            acmd.node_rel = 1'b1;
            acmd.node_idx = n_ff;
         end
         S_DEL_RD: begin
            kv_raddr = {bkt_ff, i_next[btbm_pkg::SLOT_W-1:0]};
            if (i_next >= fill_ff) begin
               fill_we    = 1'b1;
               fill_wdata = fill_ff - 1'b1;
            end
         end
         S_DEL_WR: begin
            kv_we     = 1'b1;
            key_wdata = key_rdata;
            val_wdata = val_rdata;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_IDLE;
         root_ff   <= 1'b0;
         status_ff <= btbm_pkg::STATUS_OK;
         found_ff  <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  func_ff    <= req_func;
                  key_ff     <= req_key;
                  value_ff   <= req_value;
                  n_ff       <= '0;
                  h_ff       <= '0;
                  has_par_ff <= 1'b0;
                  found_ff   <= '0;
                  if (req_func == btbm_pkg::FUNC_INSERT) begin
                     state_ff <= root_ff ? S_NODE_RD : S_ROOT;
                  end else if (req_func == btbm_pkg::FUNC_GET ||
                               req_func == btbm_pkg::FUNC_DELETE) begin
                     if (root_ff) begin
                        state_ff <= S_NODE_RD;
                     end else begin
                        status_ff <= btbm_pkg::STATUS_MISS;
                        state_ff  <= S_RESP;
                     end
                  end else begin
                     status_ff <= btbm_pkg::STATUS_FAIL;
                     state_ff  <= S_RESP;
                  end
               end
            end
            S_ROOT: begin
               root_ff  <= 1'b1;
               state_ff <= S_NODE_RD;
            end
            S_NODE_RD: begin
               state_ff <= S_NODE_EV;
            end
            S_NODE_EV: begin
               cur_ff <= node_rdata;
               if (node_rdata.has_bucket) begin
                  bkt_ff   <= node_rdata.bucket;
                  state_ff <= (func_ff == btbm_pkg::FUNC_INSERT) ? S_INS_FILL : S_LK_FILL;
               end else if (at_depth) begin
                  status_ff <= (func_ff == btbm_pkg::FUNC_INSERT) ?
                               btbm_pkg::STATUS_FAIL : btbm_pkg::STATUS_MISS;
                  state_ff  <= S_RESP;
               end else if (func_ff == btbm_pkg::FUNC_INSERT) begin
                  if (!node_rdata.has_zero && !node_rdata.has_one) begin
                     if (astat.bkt_cnt == '0) begin
                        status_ff <= btbm_pkg::STATUS_FAIL;
                        state_ff  <= S_RESP;
                     end else begin
                        ret_ff   <= S_INS_NEWB;
                        state_ff <= S_FIND1;
                     end
                  end else begin
                     state_ff <= S_INS_DESC;
                  end
               end else begin
                  if (key_bit ? !node_rdata.has_one : !node_rdata.has_zero) begin
                     status_ff <= btbm_pkg::STATUS_MISS;
                     state_ff  <= S_RESP;
                  end else begin
                     par_ff     <= node_rdata;
                     par_idx_ff <= n_ff;
                     has_par_ff <= 1'b1;
                     n_ff       <= key_bit ? node_rdata.one : node_rdata.zero;
                     h_ff       <= h_ff + 1'b1;
                     state_ff   <= S_NODE_RD;
                  end
               end
            end
            S_FIND1: begin
               state_ff <= S_FIND2;
            end
            S_FIND2: begin
               state_ff <= ret_ff;
            end
            S_INS_FILL: begin
               fill_ff <= fill_rdata;
               if (fill_rdata < btbm_pkg::FILL_W'(btbm_pkg::BUCKET_SIZE)) begin
                  state_ff <= S_INS_PUSH;
               end else if (at_depth) begin
                  status_ff <= btbm_pkg::STATUS_FAIL;
                  state_ff  <= S_RESP;
               end else begin
                  i_ff     <= '0;
                  ones_ff  <= '0;
                  zeros_ff <= '0;
                  state_ff <= S_SPL_CNT_RD;
               end
            end
            S_INS_DESC: begin
               if (key_bit ? cur_ff.has_one : cur_ff.has_zero) begin
                  n_ff     <= key_bit ? cur_ff.one : cur_ff.zero;
                  h_ff     <= h_ff + 1'b1;
                  state_ff <= S_NODE_RD;
               end else if (astat.node_cnt == '0) begin
                  status_ff <= btbm_pkg::STATUS_FAIL;
                  state_ff  <= S_RESP;
               end else begin
                  ret_ff   <= S_INS_NEWN;
                  state_ff <= S_FIND1;
               end
            end
            S_INS_NEWN: begin
               if (key_bit) begin
                  cur_ff.one     <= astat.node_pick;
                  cur_ff.has_one <= 1'b1;
               end else begin
                  cur_ff.zero     <= astat.node_pick;
                  cur_ff.has_zero <= 1'b1;
               end
               state_ff <= S_INS_LINK;
            end
            S_INS_LINK: begin
               n_ff     <= key_bit ? cur_ff.one : cur_ff.zero;
               h_ff     <= h_ff + 1'b1;
               state_ff <= S_NODE_RD;
            end
            S_INS_NEWB: begin
               bkt_ff   <= astat.bkt_pick;
               fill_ff  <= '0;
               state_ff <= S_INS_PUSH;
            end
            S_INS_PUSH: begin
               status_ff <= btbm_pkg::STATUS_OK;
               state_ff  <= S_RESP;
            end
            S_SPL_CNT_RD: begin
               state_ff <= S_SPL_CNT;
            end
            S_SPL_CNT: begin
               if (split_bit) begin
                  ones_ff <= ones_ff + 1'b1;
               end else begin
                  zeros_ff <= zeros_ff + 1'b1;
               end
               i_ff     <= i_next;
               state_ff <= (i_next >= fill_ff) ? S_SPL_CHK : S_SPL_CNT_RD;
            end
            S_SPL_CHK: begin
               if (astat.bkt_cnt < btbm_pkg::BKT_CNT_W'(need) ||
                   astat.node_cnt < btbm_pkg::NODE_CNT_W'(need)) begin
                  status_ff <= btbm_pkg::STATUS_FAIL;
                  state_ff  <= S_RESP;
               end else begin
                  ret_ff   <= (ones_ff != '0) ? S_SPL_TAKE_O : S_SPL_TAKE_Z;
                  state_ff <= S_FIND1;
               end
            end
            S_SPL_TAKE_O: begin
               bo_ff <= astat.bkt_pick;
               i_ff  <= '0;
               fo_ff <= '0;
               fz_ff <= '0;
               if (zeros_ff != '0) begin
                  ret_ff   <= S_SPL_TAKE_Z;
                  state_ff <= S_FIND1;
               end else begin
                  state_ff <= S_SPL_CP_RD;
               end
            end
            S_SPL_TAKE_Z: begin
               bz_ff    <= astat.bkt_pick;
               i_ff     <= '0;
               fo_ff    <= '0;
               fz_ff    <= '0;
               state_ff <= S_SPL_CP_RD;
            end
            S_SPL_CP_RD: begin
               state_ff <= S_SPL_CP_WR;
            end
            S_SPL_CP_WR: begin
               if (split_bit) begin
                  fo_ff <= fo_ff + 1'b1;
               end else begin
                  fz_ff <= fz_ff + 1'b1;
               end
               i_ff     <= i_next;
               state_ff <= (i_next >= fill_ff) ? S_SPL_FILL_O : S_SPL_CP_RD;
            end
            S_SPL_FILL_O: begin
               state_ff <= S_SPL_FILL_Z;
            end
            S_SPL_FILL_Z: begin
               ret_ff   <= (ones_ff != '0) ? S_SPL_NODE_O : S_SPL_NODE_Z;
               state_ff <= S_FIND1;
            end
            S_SPL_NODE_O: begin
               cur_ff.one     <= astat.node_pick;
               cur_ff.has_one <= 1'b1;
               if (zeros_ff != '0) begin
                  ret_ff   <= S_SPL_NODE_Z;
                  state_ff <= S_FIND1;
               end else begin
                  state_ff <= S_SPL_RELINK;
               end
            end
            S_SPL_NODE_Z: begin
               cur_ff.zero     <= astat.node_pick;
               cur_ff.has_zero <= 1'b1;
               state_ff        <= S_SPL_RELINK;
            end
            S_SPL_RELINK: begin
               cur_ff.has_bucket <= 1'b0;
               state_ff          <= S_INS_DESC;
            end
            S_LK_FILL: begin
               fill_ff <= fill_rdata;
               i_ff    <= '0;
               if (fill_rdata == '0) begin
                  status_ff <= btbm_pkg::STATUS_MISS;
                  state_ff  <= S_RESP;
               end else begin
                  state_ff <= S_LK_RD;
               end
            end
            S_LK_RD: begin
               state_ff <= S_LK_CMP;
            end
            S_LK_CMP: begin
               if (key_rdata == key_ff) begin
                  found_ff <= val_rdata;
                  if (func_ff == btbm_pkg::FUNC_GET) begin
                     status_ff <= btbm_pkg::STATUS_OK;
                     state_ff  <= S_RESP;
                  end else if (fill_ff == btbm_pkg::FILL_W'(1)) begin
                     state_ff <= S_LK_FREE;
                  end else begin
                     state_ff <= S_DEL_RD;
                  end
               end else if (i_next >= fill_ff) begin
                  status_ff <= btbm_pkg::STATUS_MISS;
                  state_ff  <= S_RESP;
               end else begin
                  i_ff     <= i_next;
                  state_ff <= S_LK_RD;
               end
            end
            S_LK_FREE: begin
               if (has_par_ff) begin
                  state_ff <= S_LK_UNLINK;
               end else begin
                  status_ff <= btbm_pkg::STATUS_OK;
                  state_ff  <= S_RESP;
               end
            end
            S_LK_UNLINK: begin
               status_ff <= btbm_pkg::STATUS_OK;
               state_ff  <= S_RESP;
            end
            S_DEL_RD: begin
               if (i_next >= fill_ff) begin
                  status_ff <= btbm_pkg::STATUS_OK;
                  state_ff  <= S_RESP;
               end else begin
                  state_ff <= S_DEL_WR;
               end
            end
            S_DEL_WR: begin
               i_ff     <= i_next;
               state_ff <= S_DEL_RD;
            end
            S_RESP: begin
               if (status_ff != btbm_pkg::STATUS_OK) begin
                  found_ff <= '0;
               end
               if (rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = (state_ff == S_RESP);
   assign rsp_status      = status_ff;
   assign rsp_found_value = (status_ff == btbm_pkg::STATUS_OK) ? found_ff : '0;

endmodule

FILE: src/btbm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module btbm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: src/btbm_alloc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Node and bucket pool allocator
// Free maps, free counts and a registered lowest-free search for both pools.
// ----------------------------------------------------------------------------
module btbm_alloc (
   input  logic                     clock,
   input  logic                     reset,
   input  btbm_pkg::alloc_cmd_type  cmd,
   output btbm_pkg::alloc_stat_type stat
);

   logic [btbm_pkg::NODE_POOL-1:0]   node_free_ff;
   logic [btbm_pkg::BUCKET_POOL-1:0] bkt_free_ff;
   logic [btbm_pkg::NODE_CNT_W-1:0]  node_cnt_ff;
   logic [btbm_pkg::BKT_CNT_W-1:0]   bkt_cnt_ff;
   logic [btbm_pkg::NG_W-1:0]        ng_ff;
   logic [btbm_pkg::BG_W-1:0]        bg_ff;
   logic [btbm_pkg::NODE_IDX_W-1:0]  node_pick_ff;
   logic [btbm_pkg::BKT_IDX_W-1:0]   bkt_pick_ff;
   logic                             find_d_ff;
   logic [btbm_pkg::GROUP-1:0]       node_grp;
   logic [btbm_pkg::GROUP-1:0]       bkt_grp;
   logic [btbm_pkg::LO_W-1:0]        ng_lo;
   logic [btbm_pkg::LO_W-1:0]        bg_lo;
   logic [btbm_pkg::LO_W-1:0]        n_lo;
   logic [btbm_pkg::LO_W-1:0]        b_lo;

   always_comb begin
      node_grp = '0;
      bkt_grp  = '0;
      for (int g = 0; g < btbm_pkg::NODE_GROUPS; g++) begin
         node_grp[g] = |node_free_ff[g*btbm_pkg::GROUP +: btbm_pkg::GROUP];
      end
      for (int g = 0; g < btbm_pkg::BKT_GROUPS; g++) begin
         bkt_grp[g] = |bkt_free_ff[g*btbm_pkg::GROUP +: btbm_pkg::GROUP];
      end
      ng_lo = btbm_pkg::lowest_set(node_grp);
      bg_lo = btbm_pkg::lowest_set(bkt_grp);
      n_lo  = btbm_pkg::lowest_set(node_free_ff[ng_ff*btbm_pkg::GROUP +: btbm_pkg::GROUP]);
      b_lo  = btbm_pkg::lowest_set(bkt_free_ff[bg_ff*btbm_pkg::GROUP +: btbm_pkg::GROUP]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_free_ff <= '1;
         bkt_free_ff  <= '1;
         node_cnt_ff  <= btbm_pkg::NODE_CNT_W'(btbm_pkg::NODE_POOL);
         bkt_cnt_ff   <= btbm_pkg::BKT_CNT_W'(btbm_pkg::BUCKET_POOL);
         find_d_ff    <= 1'b0;
      end else begin
         find_d_ff <= cmd.find;
         if (cmd.node_take) begin
            node_free_ff[cmd.node_idx] <= 1'b0;
            node_cnt_ff                <= node_cnt_ff - 1'b1;
         end else if (cmd.node_rel) begin
            node_free_ff[cmd.node_idx] <= 1'b1;
            node_cnt_ff                <= node_cnt_ff + 1'b1;
         end
         if (cmd.bkt_take) begin
            bkt_free_ff[cmd.bkt_idx] <= 1'b0;
            bkt_cnt_ff               <= bkt_cnt_ff - 1'b1;
         end else if (cmd.bkt_rel) begin
            bkt_free_ff[cmd.bkt_idx] <= 1'b1;
            bkt_cnt_ff               <= bkt_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.find) begin
         ng_ff <= ng_lo[btbm_pkg::NG_W-1:0];
         bg_ff <= bg_lo[btbm_pkg::BG_W-1:0];
      end
      if (find_d_ff) begin
         node_pick_ff <= {ng_ff, n_lo};
         bkt_pick_ff  <= {bg_ff, b_lo};
      end
   end

   assign stat.node_pick = node_pick_ff;
   assign stat.bkt_pick  = bkt_pick_ff;
   assign stat.node_cnt  = node_cnt_ff;
   assign stat.bkt_cnt   = bkt_cnt_ff;

endmodule
